// ===== hdl/sha_pkg.sv =====
package sha_pkg;

  typedef logic [31:0] word_t;

  // Eight hash words, index 0 is the most significant digest word
  typedef logic [7:0][31:0] hash_t;

  // Working variables of the compression rounds
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
    word_t f;
    word_t g;
    word_t h;
  } work_t;

  // Sequencer states of the top level
  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_PAD,
    ST_COMP,
    ST_FINISH
  } seq_state_t;

  // Controls from the sequencer to the compression core
  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_byte;
    logic       word_done;
    logic       start;
    logic       restart;
  } core_ctl_t;

  // Status from the compression core
  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  localparam logic [7:0]  PadByte     = 8'h80;
  localparam logic [5:0]  LenPos      = 6'd56;
  localparam logic [5:0]  LastPos     = 6'd63;
  localparam logic [5:0]  LastRound   = 6'd63;
  localparam logic [63:0] BitsPerByte = 64'd8;

  localparam hash_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t small_sig0(input word_t x);
    small_sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    small_sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_sig0(input word_t x);
    big_sig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    big_sig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  // Round constants
  function automatic word_t round_k(input logic [5:0] t);
    case (t)
      6'd0:  round_k = 32'h428a2f98;
      6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;
      6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;
      6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;
      6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;
      6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;
      6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;
      6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;
      6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;
      6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;
      6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;
      6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;
      6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;
      6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;
      6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;
      6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;
      6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;
      6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;
      6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;
      6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;
      6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;
      6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;
      6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;
      6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;
      6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;
      6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;
      6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;
      6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;
      6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;
      6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;
      6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;
      6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      6'd63: round_k = 32'hc67178f2;
      default: round_k = '0;
    endcase
  endfunction

endpackage

// ===== hdl/sha_round.sv =====
module sha_round (
  input  sha_pkg::work_t cur,
  input  sha_pkg::word_t k_in,
  input  sha_pkg::word_t w_in,
  output sha_pkg::work_t nxt
);
  import sha_pkg::*;

  word_t ch;
  word_t maj;
  word_t t1;
  word_t t2;

  // One compression round
  always_comb begin
    ch    = (cur.e & cur.f) ^ (~cur.e & cur.g);
    maj   = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
    t1    = cur.h + big_sig1(cur.e) + ch + k_in + w_in;
    t2    = big_sig0(cur.a) + maj;
    nxt.a = t1 + t2;
    nxt.b = cur.a;
    nxt.c = cur.b;
    nxt.d = cur.c;
    nxt.e = cur.d + t1;
    nxt.f = cur.e;
    nxt.g = cur.f;
    nxt.h = cur.g;
  end

endmodule

// ===== hdl/sha_core.sv =====
module sha_core (
  input  logic               clk,
  input  logic               rst_n,
  input  sha_pkg::core_ctl_t ctl,
  output sha_pkg::core_sts_t sts,
  output sha_pkg::hash_t     hash
);
  import sha_pkg::*;

  logic [23:0] acc_r;
  word_t       w_r [16];
  work_t       work_r;
  work_t       work_nxt;
  hash_t       hash_r;
  logic        busy_r;
  logic        add_r;
  logic [5:0]  rnd_r;
  word_t       w_new;
  work_t       hash_work;

  assign w_new = w_r[0] + small_sig0(w_r[1]) + w_r[9] + small_sig1(w_r[14]);

  assign hash_work = {hash_r[0], hash_r[1], hash_r[2], hash_r[3],
                      hash_r[4], hash_r[5], hash_r[6], hash_r[7]};

  sha_round u_round (
    .cur  (work_r),
    .k_in (round_k(rnd_r)),
    .w_in (w_r[0]),
    .nxt  (work_nxt)
  );

  // Gather bytes into words and run the message schedule line
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      acc_r <= {acc_r[15:0], ctl.wr_byte};
    end
    if (ctl.wr_en && ctl.word_done) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= {acc_r, ctl.wr_byte};
    end else if (busy_r) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= w_new;
    end
  end

  // Advance the working variables one round per cycle
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      work_r <= hash_work;
    end else if (busy_r) begin
      work_r <= work_nxt;
    end
  end

  // Round sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      add_r  <= 1'b0;
      rnd_r  <= '0;
    end else begin
      add_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == LastRound) begin
          busy_r <= 1'b0;
          add_r  <= 1'b1;
        end
      end
    end
  end

  // Fold the block result into the hash, or restart it
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.restart) begin
      hash_r <= HashInit;
    end else if (add_r) begin
      hash_r[0] <= hash_r[0] + work_r.a;
      hash_r[1] <= hash_r[1] + work_r.b;
      hash_r[2] <= hash_r[2] + work_r.c;
      hash_r[3] <= hash_r[3] + work_r.d;
      hash_r[4] <= hash_r[4] + work_r.e;
      hash_r[5] <= hash_r[5] + work_r.f;
      hash_r[6] <= hash_r[6] + work_r.g;
      hash_r[7] <= hash_r[7] + work_r.h;
    end
  end

  assign sts.busy = busy_r | add_r;
  assign sts.done = add_r;
  assign hash     = hash_r;

  a_busy_add_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && add_r))
    else $error("round phase and add phase overlap");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> (!busy_r && !add_r))
    else $error("block started while compression runs");

  a_last_round_add: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && rnd_r == LastRound && !ctl.start) |=> add_r)
    else $error("add phase missing after last round");

endmodule

// ===== hdl/sha256_byte_stream_hasher.sv =====
// A message byte is taken while the sequencer collects; the byte that fills a
// 64-byte block starts 64 rounds in the shared round unit, then an add step.
// End of message: pad bytes are written up to byte 63, each padded block (one
// or two) is compressed, the digest is loaded once the previous one has drained,
// then shifted out as eight digest beats; no bytes are taken while compressing.
// Reset (rst_n low, synchronous) loads the initial hash and clears all counts.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha_pkg::*;

  seq_state_t  state_r;
  seq_state_t  state_nxt;
  logic [5:0]  cnt_r;
  logic [5:0]  cnt_nxt;
  logic [63:0] len_r;
  logic [63:0] len_nxt;
  logic        padding_r;
  logic        padding_nxt;
  logic        pad_first_r;
  logic        pad_first_nxt;
  logic        len_blk_r;
  logic        len_blk_nxt;
  logic        final_r;
  logic        final_nxt;
  logic        ob_load;
  logic        fin;
  word_t       ob_r [8];
  logic [2:0]  ob_idx_r;
  logic        ob_valid_r;
  core_ctl_t   ctl;
  core_sts_t   sts;
  hash_t       hash;

  sha_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .sts   (sts),
    .hash  (hash)
  );

  // Sequencer state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      cnt_r       <= '0;
      len_r       <= '0;
      padding_r   <= 1'b0;
      pad_first_r <= 1'b0;
      len_blk_r   <= 1'b0;
      final_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      padding_r   <= padding_nxt;
      pad_first_r <= pad_first_nxt;
      len_blk_r   <= len_blk_nxt;
      final_r     <= final_nxt;
    end
  end

  // Next state, byte feed and core controls
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    padding_nxt   = padding_r;
    pad_first_nxt = pad_first_r;
    len_blk_nxt   = len_blk_r;
    final_nxt     = final_r;
    ob_load       = 1'b0;
    in_ready      = 1'b0;
    fin           = 1'b0;
    ctl           = '0;

    unique case (state_r)
      ST_COLLECT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_byte_present) begin
            ctl.wr_en   = 1'b1;
            ctl.wr_byte = in_data_byte;
            len_nxt     = len_r + BitsPerByte;
          end
          if (in_end_of_message) begin
            padding_nxt   = 1'b1;
            pad_first_nxt = 1'b1;
            len_blk_nxt   = 1'b0;
            state_nxt     = ST_PAD;
          end
          if (in_byte_present && cnt_r == LastPos) begin
            ctl.start = 1'b1;
            final_nxt = 1'b0;
            state_nxt = ST_COMP;
          end
        end
      end
      ST_PAD: begin
        ctl.wr_en = 1'b1;
        if (pad_first_r) begin
          ctl.wr_byte   = PadByte;
          pad_first_nxt = 1'b0;
          len_blk_nxt   = (cnt_r < LenPos);
        end else if (len_blk_r && cnt_r >= LenPos) begin
          ctl.wr_byte = len_r[63:56];
          len_nxt     = {len_r[55:0], 8'h00};
        end else begin
          ctl.wr_byte = 8'h00;
        end
        if (cnt_r == LastPos) begin
          fin       = !pad_first_r && len_blk_r;
          ctl.start = 1'b1;
          final_nxt = fin;
          state_nxt = ST_COMP;
          if (!fin) begin
            len_blk_nxt = 1'b1;
          end
        end
      end
      ST_COMP: begin
        if (sts.done) begin
          if (final_r) begin
            state_nxt = ST_FINISH;
          end else if (padding_r) begin
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_COLLECT;
          end
        end
      end
      ST_FINISH: begin
        if (!ob_valid_r) begin
          ob_load     = 1'b1;
          ctl.restart = 1'b1;
          len_nxt     = '0;
          padding_nxt = 1'b0;
          final_nxt   = 1'b0;
          state_nxt   = ST_COLLECT;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase

    ctl.word_done = (cnt_r[1:0] == 2'b11);
    cnt_nxt       = ctl.wr_en ? cnt_r + 6'd1 : cnt_r;
  end

  // Hold the digest and shift it out one word per beat
  always_ff @(posedge clk) begin
    if (ob_load) begin
      for (int i = 0; i < 8; i++) begin
        ob_r[i] <= hash[i];
      end
    end else if (out_valid && out_ready) begin
      for (int i = 0; i < 7; i++) begin
        ob_r[i] <= ob_r[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_valid_r <= 1'b0;
      ob_idx_r   <= '0;
    end else if (ob_load) begin
      ob_valid_r <= 1'b1;
      ob_idx_r   <= '0;
    end else if (out_valid && out_ready) begin
      ob_idx_r <= ob_idx_r + 3'd1;
      if (ob_idx_r == 3'd7) begin
        ob_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = ob_valid_r;
  assign out_digest_word = ob_r[0];
  assign out_word_index  = ob_idx_r;
  assign out_last_word   = (ob_idx_r == 3'd7);

  a_ready_core_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.busy)
    else $error("input taken while compression runs");

  a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (state_r == ST_COMP))
    else $error("compression finished outside the compress state");

  a_finish_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && !ob_valid_r) |=> (ob_valid_r && ob_idx_r == 3'd0))
    else $error("digest not loaded on finish");

endmodule

// ===== verif/sha256_byte_stream_hasher_test.sv =====
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_test;

  import sha_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 160;
  localparam int LongHold     = 600;
  localparam int LongHoldBeat = 24;
  localparam int RandomItems  = 110;

  localparam logic [0:63][31:0] RoundConst = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       eom;
    logic       drain;
  } msg_item_t;

  typedef struct {
    word_t      word;
    logic [2:0] idx;
    logic       last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // Hash state mirrored by the testbench
  word_t       hash_st [8];
  logic [7:0]  blk [64];
  int unsigned fill;
  logic [63:0] len_bits;

  msg_item_t    byte_q [$];
  digest_beat_t pending_digest_q [$];
  msg_item_t    next_item;
  digest_beat_t got_beat;

  int unsigned  errors = 0;
  int unsigned  items_sent = 0;
  int unsigned  beats_seen = 0;
  int unsigned  gap_left = 0;
  int unsigned  hold_left = 0;
  int unsigned  next_hold;
  int unsigned  cycle_count = 0;

  sha256_byte_stream_hasher uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_st[i] = InitHash[i];
    fill = 0;
    len_bits = '0;
  endfunction

  // Run the 64 rounds over the current block and fold into the hash
  function automatic void compress_block();
    word_t w [64];
    word_t a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3];
    e = hash_st[4]; f = hash_st[5]; g = hash_st[6]; h = hash_st[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + RoundConst[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
    hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
  endfunction

  // Absorb one accepted beat; on end of message pad and queue the digest
  function automatic void hash_item(input logic [7:0] data, input logic present,
                                    input logic eom);
    logic [63:0]  total;
    digest_beat_t beat;
    if (present) begin
      blk[fill] = data;
      fill = fill + 1;
      if (fill == 64) begin
        compress_block();
        len_bits += 64'd512;
        fill = 0;
      end
    end
    if (!eom) return;
    total = len_bits + 64'(fill) * 64'd8;
    blk[fill] = 8'h80;
    fill = fill + 1;
    if (fill > 56) begin
      while (fill < 64) begin
        blk[fill] = 8'h00;
        fill = fill + 1;
      end
      compress_block();
      fill = 0;
    end
    while (fill < 56) begin
      blk[fill] = 8'h00;
      fill = fill + 1;
    end
    for (int i = 0; i < 8; i++) blk[63-i] = total[8*i +: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      beat.word = hash_st[i];
      beat.idx  = 3'(i);
      beat.last = (i == 7);
      pending_digest_q.push_back(beat);
    end
    restart_hash();
  endfunction

  task automatic push_item(input logic [7:0] data, input logic present, input logic eom,
                           input logic drain);
    msg_item_t it;
    it.data = data;
    it.present = present;
    it.eom = eom;
    it.drain = drain;
    byte_q.push_back(it);
  endtask

  // Queue a message of len bytes with stray empty beats mixed in
  task automatic add_message(input int len, input logic drain);
    logic first;
    logic closed;
    first = drain;
    closed = 1'b0;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        push_item(8'($urandom), 1'b0, 1'b0, first);
        first = 1'b0;
      end
      closed = (k == len - 1) && ($urandom_range(0, 1) == 1);
      push_item(8'($urandom), 1'b1, closed, first);
      first = 1'b0;
    end
    if (!closed) push_item(8'($urandom), 1'b0, 1'b1, first);
  endtask

  // Sender: offer queued beats, waiting a drawn number of cycles between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hash_item(in_data_byte, in_byte_present, in_end_of_message);
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0 &&
                     !(byte_q[0].drain && pending_digest_q.size() > 0)) begin
          next_item = byte_q.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= next_item.data;
          in_byte_present <= next_item.present;
          in_end_of_message <= next_item.eom;
          gap_left <= ((items_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each digest beat, then stall a drawn number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (pending_digest_q.size() == 0) begin
        $display("%0t: unexpected digest beat: word %h index %0d last %b", $time,
                 out_digest_word, out_word_index, out_last_word);
        errors++;
      end else begin
        got_beat = pending_digest_q.pop_front();
        if (out_digest_word !== got_beat.word) begin
          $display("%0t: digest_word mismatch: expected %h, actual %h", $time,
                   got_beat.word, out_digest_word);
          errors++;
        end
        if (out_word_index !== got_beat.idx) begin
          $display("%0t: word_index mismatch: expected %0d, actual %0d", $time,
                   got_beat.idx, out_word_index);
          errors++;
        end
        if (out_last_word !== got_beat.last) begin
          $display("%0t: last_word mismatch: expected %b, actual %b", $time,
                   got_beat.last, out_last_word);
          errors++;
        end
      end
      beats_seen++;
      if (beats_seen + 1 == LongHoldBeat) next_hold = LongHold;
      else if ((beats_seen / 48) % 3 == 1) next_hold = 0;
      else next_hold = $urandom_range(0, 7);
      hold_left <= next_hold;
      out_ready <= (next_hold == 0);
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= (hold_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Give up if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int msg_no;
    int rand_items;
    int len;
    restart_hash();

    // Directed: stray beat, empty message, "abc", extreme bytes,
    // single byte closed on its own beat, back-to-back empty message
    push_item(8'hff, 1'b0, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1, 1'b0);
    push_item(8'h61, 1'b1, 1'b0, 1'b0);
    push_item(8'h62, 1'b1, 1'b0, 1'b0);
    push_item(8'h63, 1'b1, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b0, 1'b0);
    push_item(8'h55, 1'b0, 1'b1, 1'b0);
    push_item(8'haa, 1'b0, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b1, 1'b0);
    push_item(8'hff, 1'b0, 1'b1, 1'b0);

    // Random messages; every fourth one sits on a padding boundary
    msg_no = 0;
    rand_items = 0;
    while (rand_items < RandomItems) begin
      if (msg_no % 4 == 1) begin
        case ((msg_no / 4) % 3)
          0: len = 55;
          1: len = 56;
          default: len = 64;
        endcase
      end else begin
        len = $urandom_range(0, 9);
      end
      rand_items -= byte_q.size();
      add_message(len, msg_no == 3);
      rand_items += byte_q.size();
      msg_no++;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain everything, then let the block settle
    while (byte_q.size() != 0 || in_valid || pending_digest_q.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sha256_byte_stream_hasher.f =====
hdl/sha_pkg.sv
hdl/sha_round.sv
hdl/sha_core.sv
hdl/sha256_byte_stream_hasher.sv
verif/sha256_byte_stream_hasher_test.sv
